>>> hdl/precedence_expression_evaluator_top_defines.svh
// Assertion macros shared by the evaluator's checker.
`ifndef PRECEDENCE_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define PRECEDENCE_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PEE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evaluator check failed");

// Next-cycle implication, disabled while in reset
`define PEE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evaluator check failed");

`endif

>>> hdl/pee_pkg.sv
// Shared types and constants for the expression evaluator.
`default_nettype none

package pee_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int CNT_W  = $clog2(DATA_W);

    // Operator codes carried with each token
    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EQ  = 3'd4;

    // Pending multiplicative operator
    typedef enum logic [1:0] {
        MP_NONE = 2'd0,
        MP_MUL  = 2'd1,
        MP_DIV  = 2'd2
    } mp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic apply;
    } pee_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_mdu;
        logic is_eq;
        logic mdu_done;
    } pee_stat_t;

endpackage

`default_nettype wire

>>> hdl/pee_ifs.sv
// Token and result channel interfaces.
`default_nettype none

interface pee_tok_if import pee_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] operand;

    modport source (output valid, output cmd, output operand, input ready);
    modport sink   (input valid, input cmd, input operand, output ready);
endinterface

interface pee_res_if import pee_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic              div_by_zero;

    modport source (output valid, output value, output div_by_zero, input ready);
    modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

`default_nettype wire

>>> hdl/precedence_expression_evaluator_top.sv
// Top level of the precedence expression evaluator.
// Sequence: a token with no pending multiply/divide is accepted in S_IDLE and applied in
// S_APPLY; one that folds into a pending multiply or divide first waits in S_BUSY for the
// mul/div unit. No new token is taken until the last one has been applied.
// A result waits in its output register while the next tokens are taken.
// Reset (rst_n low, asynchronous) clears the expression state and drops res.valid.
`default_nettype none

module precedence_expression_evaluator_top import pee_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pee_tok_if.sink   tok,
    pee_res_if.source res
);

    pee_cmd_t  ctl;
    pee_stat_t stat;

    pee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok.valid),
        .tok_cmd   (tok.cmd),
        .tok_ready (tok.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    pee_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .tok_cmd         (tok.cmd),
        .tok_operand     (tok.operand),
        .res_value       (res.value),
        .res_div_by_zero (res.div_by_zero)
    );

endmodule

`default_nettype wire

>>> hdl/pee_mdu.sv
// Shared iterative multiply/divide unit, one bit per cycle.
`default_nettype none

module pee_mdu import pee_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              op_div,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output logic                   done,
    output logic [DATA_W-1:0]      result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_reg, neg_reg, zero_reg;
    // p: product or partial remainder; x: multiplicand or dividend/quotient;
    // y: multiplier or divisor magnitude
    logic [DATA_W-1:0] p_reg, p_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] y_reg, y_next;

    logic [DATA_W-1:0] mag_a, mag_b;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] rem_diff;

    // Operand magnitudes for signed division
    assign mag_a = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    assign mag_b = b[DATA_W-1] ? (DATA_W'(0) - b) : b;

    // Restoring divide step
    assign rem_sh   = {p_reg, x_reg[DATA_W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, y_reg};

    // Iteration
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            p_next    = '0;
            x_next    = op_div ? mag_a : a;
            y_next    = op_div ? mag_b : b;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg)
            begin
                if (!rem_diff[DATA_W+1])
                begin
                    p_next = rem_diff[DATA_W-1:0];
                    x_next = {x_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    p_next = rem_sh[DATA_W-1:0];
                    x_next = {x_reg[DATA_W-2:0], 1'b0};
                end
            end
            else
            begin
                p_next = p_reg + (y_reg[0] ? x_reg : DATA_W'(0));
                x_next = {x_reg[DATA_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[DATA_W-1:1]};
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= op_div;
            neg_reg  <= a[DATA_W-1] ^ b[DATA_W-1];
            zero_reg <= (b == '0);
        end
        p_reg <= p_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    // Product, or signed quotient; zero divisor gives zero
    always_comb
    begin
        if (!div_reg)
            result = p_reg;
        else if (zero_reg)
            result = '0;
        else if (neg_reg)
            result = DATA_W'(0) - x_reg;
        else
            result = x_reg;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

>>> hdl/pee_dp.sv
// Evaluator datapath: token latch, accumulator, term, pending operators.
`default_nettype none

module pee_dp import pee_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pee_cmd_t          ctl,
    output pee_stat_t              stat,
    input  wire logic [CMD_W-1:0]  tok_cmd,
    input  wire logic [DATA_W-1:0] tok_operand,
    output logic [DATA_W-1:0]      res_value,
    output logic                   res_div_by_zero
);

    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] opnd_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] term_reg, term_next;
    logic              add_pend_reg, add_pend_next;
    mp_t               mul_pend_reg, mul_pend_next;
    logic              err_reg, err_next;
    logic [DATA_W-1:0] value_reg;
    logic              dbz_reg;

    logic              mdu_done;
    logic [DATA_W-1:0] mdu_result;
    logic [DATA_W-1:0] t_val;
    logic [DATA_W-1:0] sum;
    logic              err_hit;

    pee_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.start),
        .op_div (mul_pend_reg == MP_DIV),
        .a      (term_reg),
        .b      (tok_operand),
        .done   (mdu_done),
        .result (mdu_result)
    );

    // Status to controller
    assign stat.need_mdu = (mul_pend_reg == MP_MUL) || (mul_pend_reg == MP_DIV);
    assign stat.is_eq    = (cmd_reg == CMD_EQ);
    assign stat.mdu_done = mdu_done;

    // Token latch
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= tok_cmd;
            opnd_reg <= tok_operand;
        end
    end

    // Folded operand: unit result when a chain is pending
    always_comb
    begin
        case (mul_pend_reg) inside
            MP_MUL, MP_DIV: t_val = mdu_result;
            default:        t_val = opnd_reg;
        endcase
    end

    assign err_hit = (mul_pend_reg == MP_DIV) && (opnd_reg == '0);
    assign sum     = add_pend_reg ? (acc_reg - t_val) : (acc_reg + t_val);

    // State update on apply
    always_comb
    begin
        acc_next      = acc_reg;
        term_next     = term_reg;
        add_pend_next = add_pend_reg;
        mul_pend_next = mul_pend_reg;
        err_next      = err_reg;
        if (ctl.apply)
        begin
            err_next = err_reg | err_hit;
            unique case (cmd_reg) inside
                CMD_MUL, CMD_DIV:
                begin
                    term_next     = t_val;
                    mul_pend_next = (cmd_reg == CMD_MUL) ? MP_MUL : MP_DIV;
                end
                CMD_EQ:
                begin
                    acc_next      = '0;
                    term_next     = '0;
                    add_pend_next = 1'b0;
                    mul_pend_next = MP_NONE;
                    err_next      = 1'b0;
                end
                default:
                begin
                    acc_next      = sum;
                    term_next     = '0;
                    add_pend_next = (cmd_reg == CMD_SUB);
                    mul_pend_next = MP_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            term_reg     <= '0;
            add_pend_reg <= 1'b0;
            mul_pend_reg <= MP_NONE;
            err_reg      <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            term_reg     <= term_next;
            add_pend_reg <= add_pend_next;
            mul_pend_reg <= mul_pend_next;
            err_reg      <= err_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.apply && stat.is_eq)
        begin
            value_reg <= sum;
            dbz_reg   <= err_reg | err_hit;
        end
    end

    assign res_value       = value_reg;
    assign res_div_by_zero = dbz_reg;

endmodule

`default_nettype wire

>>> hdl/pee_ctrl.sv
// Evaluator controller: token handshake, unit sequencing, result handshake.
`default_nettype none

module pee_ctrl import pee_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tok_valid,
    input  wire logic [CMD_W-1:0] tok_cmd,
    output logic                  tok_ready,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output pee_cmd_t              ctl,
    input  wire pee_stat_t        stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   take;
    logic   out_free;

    assign tok_ready = (state_reg == S_IDLE);
    assign take      = tok_valid && tok_ready && (tok_cmd <= CMD_EQ);
    assign out_free  = !res_valid_reg || res_ready;

    // Commands and next state
    always_comb
    begin
        ctl.load   = take;
        ctl.start  = take && stat.need_mdu;
        ctl.apply  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                    state_next = stat.need_mdu ? S_BUSY : S_APPLY;
            end
            S_BUSY:
            begin
                if (stat.mdu_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                // an equals beat waits for the result register to free up
                if (!stat.is_eq || out_free)
                begin
                    ctl.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        res_valid_next = (ctl.apply && stat.is_eq) ? 1'b1
                                                   : (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

>>> hdl/pee_checker.sv
// Port-level checks for the evaluator, bound to the top level.
`default_nettype none
`include "precedence_expression_evaluator_top_defines.svh"

module pee_checker import pee_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              tok_valid,
    input wire logic              tok_ready,
    input wire logic [CMD_W-1:0]  tok_cmd,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [DATA_W-1:0] res_value,
    input wire logic              res_div_by_zero
);

    // A result beat holds until taken
    `PEE_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)
    `PEE_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_value) && $stable(res_div_by_zero))
    // After a real token is taken, tok_ready is low in the next cycle
    `PEE_ASSERT_NEXT(a_busy_after_tok, clk, rst_n, tok_valid && tok_ready && (tok_cmd <= CMD_EQ), !tok_ready)
    // Undefined operator codes are dropped without stalling
    `PEE_ASSERT_NEXT(a_skip_bad_cmd, clk, rst_n, tok_valid && tok_ready && (tok_cmd > CMD_EQ), tok_ready)
    // A new result follows a cycle in which the token side was busy
    `PEE_ASSERT_NOW(a_res_after_work, clk, rst_n, $rose(res_valid), !$past(tok_ready))

endmodule

bind precedence_expression_evaluator_top pee_checker u_pee_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tok_valid       (tok.valid),
    .tok_ready       (tok.ready),
    .tok_cmd         (tok.cmd),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_value       (res.value),
    .res_div_by_zero (res.div_by_zero)
);

`default_nettype wire

>>> dv/precedence_expression_evaluator_top_test.sv
// Self-checking testbench for the precedence expression evaluator top level.
module precedence_expression_evaluator_top_test import pee_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Operator codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_RSV_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV_C = 3'd7;

    localparam int IDLE_PCT      = 23;
    localparam int RANDOM_TOKENS = 1700;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FROM     = 900;
    localparam int CALM_TO       = 1200;
    localparam int DRAIN_CYCLES  = 100;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] operand;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              div_by_zero;
    } expr_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pee_tok_if tok ();
    pee_res_if res ();

    precedence_expression_evaluator_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok),
        .res   (res)
    );

    always #2 clk = ~clk;

    // Token stream waiting to be offered, and expression values still owed
    token_t       token_q[$];
    expr_result_t expr_value_q[$];
    token_t       cur_tok;
    int           tokens_accepted = 0;
    int           total_tokens    = 0;
    int           errors          = 0;
    int           hold_left       = 0;
    logic         hold_armed      = 1'b1;
    logic         calm;

    // Expression state as the block should hold it
    logic [DATA_W-1:0] ev_acc      = '0;
    logic [DATA_W-1:0] ev_term     = '0;
    logic              ev_subtract = 1'b0;
    mp_t               ev_mul_op   = MP_NONE;
    logic              ev_div_err  = 1'b0;

    assign calm = (tokens_accepted >= CALM_FROM) && (tokens_accepted < CALM_TO);

    // Signed divide on bit patterns, truncating toward zero; zero divisor gives 0
    function automatic logic [DATA_W-1:0] div_trunc(logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] q;
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        if (mb == '0)
            return '0;
        q = ma / mb;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
    endfunction

    // Apply one accepted token; an equals token queues the expression value
    function automatic void evaluate_token(token_t t);
        logic [DATA_W-1:0] folded;
        expr_result_t      r;
        if (t.cmd > CMD_EQ)
            return;
        case (ev_mul_op)
            MP_MUL: folded = ev_term * t.operand;
            MP_DIV:
            begin
                if (t.operand == '0)
                    ev_div_err = 1'b1;
                folded = div_trunc(ev_term, t.operand);
            end
            default: folded = t.operand;
        endcase
        if (t.cmd == CMD_MUL || t.cmd == CMD_DIV)
        begin
            ev_term   = folded;
            ev_mul_op = (t.cmd == CMD_MUL) ? MP_MUL : MP_DIV;
            return;
        end
        ev_acc = ev_subtract ? ev_acc - folded : ev_acc + folded;
        if (t.cmd == CMD_EQ)
        begin
            r.value       = ev_acc;
            r.div_by_zero = ev_div_err;
            expr_value_q.push_back(r);
            ev_acc      = '0;
            ev_term     = '0;
            ev_subtract = 1'b0;
            ev_mul_op   = MP_NONE;
            ev_div_err  = 1'b0;
        end
        else
        begin
            ev_subtract = (t.cmd == CMD_SUB);
            ev_mul_op   = MP_NONE;
            ev_term     = '0;
        end
    endfunction

    function automatic void add_token(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v);
        token_t t;
        t.cmd     = c;
        t.operand = v;
        token_q.push_back(t);
    endfunction

    // Operand mix: zero and the extremes often, small values, full random
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = 32'd1;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = 32'h7FFF_FFFF;
            5, 6:
            begin
                v = $urandom_range(1, 20);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [CMD_W-1:0] pick_link_op();
        case ($urandom_range(3))
            0: return CMD_ADD;
            1: return CMD_SUB;
            2: return CMD_MUL;
            default: return CMD_DIV;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_reserved_op();
        case ($urandom_range(2))
            0: return CMD_RSV_A;
            1: return CMD_RSV_B;
            default: return CMD_RSV_C;
        endcase
    endfunction

    // Token driver: holds a beat until accepted, idles at random
    always @(posedge clk)
    begin
        if (!rst_n)
            tok.valid <= 1'b0;
        else
        begin
            if (tok.valid && tok.ready)
            begin
                evaluate_token(cur_tok);
                tokens_accepted <= tokens_accepted + 1;
            end
            if (!tok.valid || tok.ready)
            begin
                if (token_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_tok     = token_q.pop_front();
                    tok.valid   <= 1'b1;
                    tok.cmd     <= cur_tok.cmd;
                    tok.operand <= cur_tok.operand;
                end
                else
                    tok.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block backs up and stalls its input
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && tokens_accepted >= HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // Result monitor: compare each accepted beat with the oldest owed value
    always @(posedge clk)
    begin
        expr_result_t want;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expr_value_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual value %h dbz %b",
                             $time, res.value, res.div_by_zero);
                end
                else
                begin
                    want = expr_value_q.pop_front();
                    if (res.value !== want.value)
                    begin
                        errors++;
                        $display("%0t: value mismatch: expected %h, actual %h",
                                 $time, want.value, res.value);
                    end
                    if (res.div_by_zero !== want.div_by_zero)
                    begin
                        errors++;
                        $display("%0t: div_by_zero mismatch: expected %b, actual %b",
                                 $time, want.div_by_zero, res.div_by_zero);
                    end
                end
            end
            res.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int n_defined;
        int n_terms;
        tok.valid   = 1'b0;
        tok.cmd     = CMD_ADD;
        tok.operand = '0;
        res.ready   = 1'b0;

        // Directed: extremes, wrap, leading multiply chain, precedence,
        // divide by zero, most negative over minus one, ignored codes
        add_token(CMD_EQ,    32'd7);
        add_token(CMD_EQ,    32'h8000_0000);
        add_token(CMD_ADD,   32'h7FFF_FFFF);
        add_token(CMD_EQ,    32'd1);
        add_token(CMD_MUL,   32'd3);
        add_token(CMD_MUL,   32'd4);
        add_token(CMD_EQ,    32'd5);
        add_token(CMD_SUB,   32'd10);
        add_token(CMD_MUL,   32'd2);
        add_token(CMD_EQ,    32'd3);
        add_token(CMD_DIV,   32'd7);
        add_token(CMD_ADD,   32'd0);
        add_token(CMD_EQ,    32'd1);
        add_token(CMD_DIV,   32'h8000_0000);
        add_token(CMD_EQ,    32'hFFFF_FFFF);
        add_token(CMD_DIV,   -32'd7);
        add_token(CMD_EQ,    32'd2);
        add_token(CMD_RSV_A, 32'd9);
        add_token(CMD_RSV_B, 32'hFFFF_FFFF);
        add_token(CMD_RSV_C, 32'd11);
        add_token(CMD_DIV,   32'd100);
        add_token(CMD_SUB,   32'd7);
        add_token(CMD_MUL,   32'hFFFF_FFFF);
        add_token(CMD_EQ,    32'hFFFF_FFFF);

        // Random whole expressions with a little ignored-code noise
        n_defined = 0;
        while (n_defined < RANDOM_TOKENS)
        begin
            n_terms = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            for (int i = 0; i < n_terms; i++)
            begin
                if ($urandom_range(99) < 4)
                    add_token(pick_reserved_op(), $urandom);
                add_token((i == n_terms - 1) ? CMD_EQ : pick_link_op(), pick_operand());
                n_defined++;
            end
        end
        total_tokens = token_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (tokens_accepted != total_tokens)
            @(posedge clk);
        while (expr_value_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("precedence_expression_evaluator_top verification clean");
        else
            $display("precedence_expression_evaluator_top verification failed");
        $finish;
    end

    // Hang guard
    initial
    begin
        #2_000_000;
        $display("precedence_expression_evaluator_top verification failed");
        $finish;
    end

endmodule
